>>> src/csmd_pkg.sv
// Shared types, codes and register-map constants for the shadow map decoder.
package csmd_pkg;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    MODE_PORT_WRITE = 2'd0,
    MODE_PORT_READ  = 2'd1,
    MODE_ROUTE      = 2'd2,
    MODE_UNUSED     = 2'd3
  } mode_t;

  localparam int unsigned STORE_DEPTH = 18;
  localparam int unsigned SLOT_W      = 5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [7:0]        byte_t;

  // Register indexes with special handling
  localparam byte_t IDX_ID_LOW  = 8'h04;
  localparam byte_t IDX_ID_HIGH = 8'h08;
  localparam byte_t ID_LOW_MASK  = 8'h1C;
  localparam byte_t ID_HIGH_MASK = 8'h1F;
  localparam byte_t NO_DATA      = 8'hFF;

  // Store slots of the registers used by the address decoder
  localparam slot_t SLOT_SEG_ROUTE = 5'd4;   // index 0x09
  localparam slot_t SLOT_LOW_MAP0  = 5'd5;   // index 0x0A
  localparam slot_t SLOT_LOW_MAP1  = 5'd6;   // index 0x0B
  localparam slot_t SLOT_LOW_MAP2  = 5'd7;   // index 0x0C
  localparam slot_t SLOT_LOW_MAP3  = 5'd8;   // index 0x0D
  localparam slot_t SLOT_UP_MAP0   = 5'd9;   // index 0x0E
  localparam slot_t SLOT_UP_MAP1   = 5'd10;  // index 0x0F

  // 16K block number of 0x40000, the bottom of the decoded window
  localparam logic [5:0] WINDOW_BLOCK = 6'h10;

  typedef struct packed {
    logic  hit;
    slot_t slot;
  } slot_lookup_t;

  // Map a register index to its place in the store
  function automatic slot_lookup_t slot_of(input byte_t ix);
    slot_lookup_t r;
    r.hit  = 1'b0;
    r.slot = '0;
    if (ix >= 8'h04 && ix <= 8'h06) begin
      r.hit  = 1'b1;
      r.slot = SLOT_W'(ix - 8'h04);
    end else if (ix >= 8'h08 && ix <= 8'h13) begin
      r.hit  = 1'b1;
      r.slot = SLOT_W'(ix - 8'h05);
    end else if (ix >= 8'h28 && ix <= 8'h2A) begin
      r.hit  = 1'b1;
      r.slot = SLOT_W'(ix - 8'h19);
    end
    return r;
  endfunction

endpackage

>>> src/chipset_shadow_map_decoder.sv
// Top level: index/data register port and memory route decoder.
//
// Usage:
//   Input beats arrive on in_tvalid/in_tready. in_tuser selects the operation
//   (port write, port read, route query) and which port; in_tdata carries the
//   written byte and the 20-bit query address. Every beat gives exactly one
//   result beat on out_tvalid/out_tready: the read byte (0xFF if nothing is
//   readable) and the read/write routing plus window flag of a query.
//   The block is an input register followed by a result register with the
//   decode logic between them. A taken input beat waits in the input register
//   and then moves into the result register, where out_tvalid rises;
//   one beat per cycle is sustained while out_tready stays high.
//   The register store is 18 flops-wide bytes, updated when a beat moves
//   from the input register into the result register, so accesses apply in
//   arrival order.
//   A stalled receiver holds the result register; the input register still
//   takes one more beat, after which in_tready drops until the result drains.
//   Synchronous reset (rst_n low) empties both stages and clears the index
//   register and every register in the store.
module chipset_shadow_map_decoder
  import csmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] write_data, [27:8] mem_address, [31:28] zero
  input  logic [2:0]  in_tuser,   // [1:0] mode, [2] port_odd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] read_external,
                                  // [9] write_external, [10] in_window, [15:11] zero
);

  // Input stage
  logic        s1_valid_r;
  mode_t       s1_mode_r;
  logic        s1_odd_r;
  byte_t       s1_wdata_r;
  logic [19:0] s1_addr_r;

  // Result stage
  logic        out_valid_r;
  byte_t       out_rdata_r;
  logic        out_rext_r;
  logic        out_wext_r;
  logic        out_win_r;

  // Architectural state
  byte_t       index_r;
  byte_t       store_r [STORE_DEPTH];

  logic        advance;
  logic        in_fire;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r  <= mode_t'(in_tuser[1:0]);
      s1_odd_r   <= in_tuser[2];
      s1_wdata_r <= in_tdata[7:0];
      s1_addr_r  <= in_tdata[27:8];
    end
  end

  // Decode of the current beat
  slot_lookup_t idx_lu;
  byte_t        rdata_nxt;
  logic         rext_nxt;
  logic         wext_nxt;
  logic         win_nxt;
  logic         index_we;
  logic         store_we;
  logic [31:0]  low_map;
  logic [15:0]  up_map;
  byte_t        seg_route;
  logic [5:0]   low_block;
  logic [4:0]   low_n;
  logic [3:0]   up_n;
  logic [1:0]   seg;

  assign idx_lu    = slot_of(index_r);
  assign low_map   = {store_r[SLOT_LOW_MAP3], store_r[SLOT_LOW_MAP2],
                      store_r[SLOT_LOW_MAP1], store_r[SLOT_LOW_MAP0]};
  assign up_map    = {store_r[SLOT_UP_MAP1], store_r[SLOT_UP_MAP0]};
  assign seg_route = store_r[SLOT_SEG_ROUTE];
  assign low_block = s1_addr_r[19:14] - WINDOW_BLOCK;
  assign low_n     = low_block[4:0];
  assign up_n      = s1_addr_r[17:14];
  assign seg       = up_n[3:2];

  always_comb begin
    rdata_nxt = NO_DATA;
    rext_nxt  = 1'b0;
    wext_nxt  = 1'b0;
    win_nxt   = 1'b0;
    index_we  = 1'b0;
    store_we  = 1'b0;
    unique case (s1_mode_r)
      MODE_PORT_WRITE: begin
        index_we = !s1_odd_r;
        store_we = s1_odd_r && idx_lu.hit;
      end
      MODE_PORT_READ: begin
        if (s1_odd_r && idx_lu.hit) begin
          rdata_nxt = store_r[idx_lu.slot];
          if (index_r == IDX_ID_LOW) begin
            rdata_nxt = rdata_nxt & ID_LOW_MASK;
          end else if (index_r == IDX_ID_HIGH) begin
            rdata_nxt = rdata_nxt & ID_HIGH_MASK;
          end
        end
      end
      MODE_ROUTE: begin
        if (s1_addr_r[19:18] == 2'b11) begin
          // 0xC0000-0xFFFFF: per-16K override, else per-64K segment routing
          win_nxt = 1'b1;
          if (up_map[up_n]) begin
            rext_nxt = 1'b1;
            wext_nxt = 1'b1;
          end else begin
            rext_nxt = seg_route[3'd3 - {1'b0, seg}];
            wext_nxt = seg_route[3'd7 - {1'b0, seg}];
          end
        end else if (s1_addr_r[19:18] != 2'b00) begin
          // 0x40000-0xBFFFF: per-16K bit routes both directions
          win_nxt  = 1'b1;
          rext_nxt = low_map[low_n];
          wext_nxt = low_map[low_n];
        end
      end
      default: begin
      end
    endcase
  end

  // State update as the beat leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (advance) begin
      if (index_we) begin
        index_r <= s1_wdata_r;
      end
      if (store_we) begin
        store_r[idx_lu.slot] <= s1_wdata_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rdata_r <= rdata_nxt;
      out_rext_r  <= rext_nxt;
      out_wext_r  <= wext_nxt;
      out_win_r   <= win_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_win_r, out_wext_r, out_rext_r, out_rdata_r};

  // Checks
  a_ext_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[8] || out_tdata[9]) |-> out_tdata[10])
    else $error("external routing outside the decoded window");

  a_read_no_route: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] != NO_DATA) |-> (out_tdata[10:8] == 3'b000))
    else $error("read data and route flags on the same beat");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input stage lost a beat while stalled");

  a_index_write: assert property (@(posedge clk) disable iff (!rst_n)
    advance && index_we |=> index_r == $past(s1_wdata_r))
    else $error("index port write not taken");

endmodule

>>> sim/shadow_route_checker.sv
// Checker for the shadow map decoder: predicts each result beat and compares it.
module shadow_route_checker
  import csmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] write_data, [27:8] mem_address, [31:28] zero
  input  logic [2:0]  in_tuser,   // [1:0] mode, [2] port_odd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] read_data, [8] read_external,
                                  // [9] write_external, [10] in_window, [15:11] zero
  output int unsigned mismatch_count,
  output int unsigned results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [19:0] WINDOW_BASE   = 20'h40000;
  localparam logic [19:0] UPPER_BASE    = 20'hC0000;
  localparam logic [7:0]  SEG_ROUTE_IDX = 8'h09;
  localparam logic [7:0]  LOW_MAP_IDX   = 8'h0A;
  localparam logic [7:0]  UP_MAP_IDX    = 8'h0E;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_external;
    logic       write_external;
    logic       in_window;
  } route_result_t;

  // Shadow copy of the chip's register file, indexed by the full port index
  logic [7:0]    shadow_index;
  logic [7:0]    shadow_regs [256];
  route_result_t routes_due [$];
  int unsigned   fails;

  function automatic logic reg_present(input logic [7:0] ix);
    return ix inside {[8'h04:8'h06], [8'h08:8'h13], [8'h28:8'h2A]};
  endfunction

  function automatic logic [7:0] reg_read(input logic [7:0] ix);
    return reg_present(ix) ? shadow_regs[ix] : 8'h00;
  endfunction

  // Apply one access to the shadow state and work out its result beat
  function automatic route_result_t apply_access(input mode_t m, input logic odd,
                                                 input logic [7:0] wd,
                                                 input logic [19:0] addr);
    route_result_t r;
    logic [19:0]   off;
    logic [3:0]    up_blk;
    logic [4:0]    lo_blk;
    logic [7:0]    map;
    logic [7:0]    seg_route;
    logic [1:0]    seg;
    r = '{read_data: NO_DATA, default: 1'b0};
    case (m)
      MODE_PORT_WRITE: begin
        if (!odd) shadow_index = wd;
        else if (reg_present(shadow_index)) shadow_regs[shadow_index] = wd;
      end
      MODE_PORT_READ: begin
        if (odd && reg_present(shadow_index)) begin
          r.read_data = shadow_regs[shadow_index];
          if (shadow_index == IDX_ID_LOW) r.read_data &= ID_LOW_MASK;
          else if (shadow_index == IDX_ID_HIGH) r.read_data &= ID_HIGH_MASK;
        end
      end
      MODE_ROUTE: begin
        if (addr >= UPPER_BASE) begin
          off    = addr - UPPER_BASE;
          up_blk = off[17:14];
          map    = reg_read(UP_MAP_IDX + 8'(up_blk[3]));
          r.in_window = 1'b1;
          if (map[up_blk[2:0]]) begin
            r.read_external  = 1'b1;
            r.write_external = 1'b1;
          end else begin
            // per-64K routing from the segment register
            seg       = up_blk[3:2];
            seg_route = reg_read(SEG_ROUTE_IDX);
            r.read_external  = seg_route[3 - int'(seg)];
            r.write_external = seg_route[7 - int'(seg)];
          end
        end else if (addr >= WINDOW_BASE) begin
          off    = addr - WINDOW_BASE;
          lo_blk = off[18:14];
          map    = reg_read(LOW_MAP_IDX + 8'(lo_blk[4:3]));
          r.in_window      = 1'b1;
          r.read_external  = map[lo_blk[2:0]];
          r.write_external = map[lo_blk[2:0]];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict on every input beat, compare on every result beat
  always @(posedge clk) begin
    route_result_t exp_r;
    route_result_t got;
    if (!rst_n) begin
      shadow_index = '0;
      for (int i = 0; i < 256; i++) shadow_regs[i] = '0;
      routes_due.delete();
      fails = 0;
    end else begin
      if (in_tvalid && in_tready)
        routes_due.push_back(apply_access(mode_t'(in_tuser[1:0]), in_tuser[2],
                                          in_tdata[7:0], in_tdata[27:8]));
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[7:0], out_tdata[8], out_tdata[9], out_tdata[10]};
        if (routes_due.size() == 0) begin
          $error("result beat %04h with no access outstanding", out_tdata);
          fails++;
        end else begin
          exp_r = routes_due.pop_front();
          if (got.read_data !== exp_r.read_data) begin
            $error("read_data: expected %02h, got %02h", exp_r.read_data, got.read_data);
            fails++;
          end
          if (got.read_external !== exp_r.read_external) begin
            $error("read_external: expected %0b, got %0b",
                   exp_r.read_external, got.read_external);
            fails++;
          end
          if (got.write_external !== exp_r.write_external) begin
            $error("write_external: expected %0b, got %0b",
                   exp_r.write_external, got.write_external);
            fails++;
          end
          if (got.in_window !== exp_r.in_window) begin
            $error("in_window: expected %0b, got %0b", exp_r.in_window, got.in_window);
            fails++;
          end
        end
      end
    end
    mismatch_count <= fails;
    results_due    <= routes_due.size();
  end

endmodule

>>> sim/tb_chipset_shadow_map_decoder.sv
// Testbench top for the shadow map decoder: stimulus, back-pressure and verdict.
module tb_chipset_shadow_map_decoder;
  import csmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned PHASE_BEATS  = 275;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [7:0] write_data, [27:8] mem_address, [31:28] zero
  logic [2:0]  in_tuser = '0;   // [1:0] mode, [2] port_odd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] read_data, [8] read_external,
                                // [9] write_external, [10] in_window, [15:11] zero
  int unsigned mismatch_count;
  int unsigned results_due;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned beats_sent = 0;

  chipset_shadow_map_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  shadow_route_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Cycles since the last beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Present one beat, with random gaps ahead of it, and hold until accepted
  task automatic send_beat(input mode_t m, input logic odd, input logic [7:0] wd,
                           input logic [19:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, addr, wd};
    in_tuser  <= {odd, m};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_index();
    int unsigned r;
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    if ($urandom_range(1) == 0) return 8'($urandom_range(8'h0F, 8'h09));
    r = $urandom_range(17);
    if (r < 3) return 8'(8'h04 + r);
    if (r < 15) return 8'(8'h08 + r - 3);
    return 8'(8'h28 + r - 15);
  endfunction

  function automatic logic [19:0] pick_address();
    if ($urandom_range(4) == 0) return 20'($urandom_range(20'hFFFFF));
    return 20'($urandom_range(20'hFFFFF, 20'h40000));
  endfunction

  // Mostly well-formed index/data sequences and queries, some raw noise
  task automatic random_phase(input int unsigned beats);
    int unsigned stop;
    int unsigned pick;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_beat(MODE_PORT_WRITE, 1'b0, pick_index(), 20'($urandom));
        send_beat(MODE_PORT_WRITE, 1'b1, 8'($urandom), 20'($urandom));
        if ($urandom_range(1) == 1)
          send_beat(MODE_PORT_READ, 1'b1, 8'($urandom), 20'($urandom));
      end else if (pick < 45) begin
        send_beat(MODE_PORT_WRITE, 1'b0, pick_index(), 20'($urandom));
        send_beat(MODE_PORT_READ, 1'b1, 8'($urandom), 20'($urandom));
      end else if (pick < 85) begin
        send_beat(MODE_ROUTE, 1'($urandom), 8'($urandom), pick_address());
      end else begin
        send_beat(mode_t'($urandom_range(3)), 1'($urandom), 8'($urandom), 20'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: window edges with cleared maps, ID masks, map bits, odd cases
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'h00000);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'h3FFFF);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'h40000);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'hBFFFF);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'hC0000);
    send_beat(MODE_ROUTE, 1'b1, 8'hFF, 20'hFFFFF);
    send_beat(MODE_PORT_WRITE, 1'b0, IDX_ID_LOW, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b1, 8'hFF, 20'hFFFFF);
    send_beat(MODE_PORT_READ, 1'b1, 8'h00, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b0, IDX_ID_HIGH, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b1, 8'hFF, 20'h00000);
    send_beat(MODE_PORT_READ, 1'b1, 8'h00, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b0, 8'h09, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b1, 8'hA5, 20'h00000);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'hC0000);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'hF0000);
    send_beat(MODE_PORT_WRITE, 1'b0, 8'h0A, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b1, 8'h01, 20'h00000);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'h40000);
    send_beat(MODE_PORT_WRITE, 1'b0, 8'h0E, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b1, 8'h80, 20'h00000);
    send_beat(MODE_ROUTE, 1'b0, 8'h00, 20'hDC000);
    // missing register: write ignored, read gives all ones
    send_beat(MODE_PORT_WRITE, 1'b0, 8'h07, 20'h00000);
    send_beat(MODE_PORT_WRITE, 1'b1, 8'h55, 20'h00000);
    send_beat(MODE_PORT_READ, 1'b1, 8'h00, 20'h00000);
    // index port read and the unused mode
    send_beat(MODE_PORT_READ, 1'b0, 8'h00, 20'h00000);
    send_beat(MODE_UNUSED, 1'b1, 8'hFF, 20'hFFFFF);

    // Random: sender light / receiver heavy, then swapped, then full rate
    send_idle_pct = 10;
    recv_idle_pct = 66;
    random_phase(PHASE_BEATS);
    wait_drained();
    send_idle_pct = 66;
    recv_idle_pct = 10;
    random_phase(PHASE_BEATS);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_BEATS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
src/csmd_pkg.sv
src/chipset_shadow_map_decoder.sv
sim/shadow_route_checker.sv
sim/tb_chipset_shadow_map_decoder.sv
